### sv/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers for the ChaCha20 stream cipher unit.
// ----------------------------------------------------------------------------
package cc20_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_0_7     = 3'd0,
        REG_KEY_8_15    = 3'd1,
        REG_KEY_16_23   = 3'd2,
        REG_KEY_24_31   = 3'd3,
        REG_NONCE_0_7   = 3'd4,
        REG_NONCE_8_11  = 3'd5,
        REG_START_CNT   = 3'd6,
        REG_DERIVE      = 3'd7
    } t_cfg_reg;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646E;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2D32;
    localparam logic [31:0] SIGMA_3 = 32'h6B20_6574;

    localparam int unsigned NONCE_STEP    = 32'h5A;
    localparam int          DOUBLE_ROUNDS = 10;
    localparam int          QR_STEPS      = 4;
    localparam int          ROUND_STEPS   = DOUBLE_ROUNDS * 2 * QR_STEPS;
    localparam int          ROUND_CNT_W   = $clog2(ROUND_STEPS);

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } t_out_word;

    typedef struct packed {
        logic       accept;
        logic       init;
        logic       round;
        logic [1:0] step;
        logic       diag;
        logic       fin;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic need_block;
        logic out_busy;
    } t_dp_status;

    function automatic logic [7:0] nonce_pad(input int unsigned idx);
        logic [31:0] prod;
        prod = idx * NONCE_STEP;
        return prod[7:0];
    endfunction

endpackage

### sv/cc20_ctrl.sv
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: accepts a word, runs block generation when needed, emits result.
// ----------------------------------------------------------------------------
module cc20_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  cc20_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output cc20_pkg::t_dp_cmd     o_cmd
);
    import cc20_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROUND,
        S_FINAL,
        S_EMIT
    } t_state;

    t_state                 r_state, n_state;
    logic [ROUND_CNT_W-1:0] r_cnt, n_cnt;
    logic                   accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_status.out_busy;
    assign accept     = o_in_ready && i_in_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.need_block ? S_INIT : S_EMIT;
                end
            end
            S_INIT: begin
                n_cnt   = '0;
                n_state = S_ROUND;
            end
            S_ROUND: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ROUND_CNT_W'(ROUND_STEPS - 1)) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.init   = (r_state == S_INIT);
        o_cmd.round  = (r_state == S_ROUND);
        o_cmd.step   = r_cnt[1:0];
        o_cmd.diag   = r_cnt[2];
        o_cmd.fin    = (r_state == S_FINAL);
        o_cmd.emit   = (r_state == S_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### sv/cc20_datapath.sv
// ----------------------------------------------------------------------------
// cc20_datapath
// Config registers, block state, quarter-round step unit and output register.
// ----------------------------------------------------------------------------
module cc20_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  cc20_pkg::t_in_word              i_in_word,
    input  logic                            i_out_ready,
    input  cc20_pkg::t_dp_cmd               i_cmd,
    output cc20_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output cc20_pkg::t_out_word             o_out_word
);
    import cc20_pkg::*;

    logic [255:0] r_key;
    logic [95:0]  r_nonce;
    logic [31:0]  r_start;
    logic         r_derive;

    logic [31:0]  r_x [16];
    logic [31:0]  n_x [16];
    logic [31:0]  init [16];
    logic [95:0]  nonce_eff;

    logic [5:0]   r_pos;
    logic [31:0]  r_counter;
    logic         r_in_msg;
    logic [7:0]   r_data;
    logic         r_last;
    logic         r_out_valid;
    t_out_word    r_out;

    logic [31:0]  ks_word;
    logic [7:0]   ks_byte;

    assign o_status.need_block = !r_in_msg || (r_pos == 6'd0);
    assign o_status.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid         = r_out_valid;
    assign o_out_word          = r_out;

    assign ks_word = r_x[r_pos[5:2]];
    assign ks_byte = ks_word[{r_pos[1:0], 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key    <= '0;
            r_nonce  <= '0;
            r_start  <= 32'd1;
            r_derive <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_KEY_0_7:    r_key[63:0]    <= i_cfg_data;
                REG_KEY_8_15:   r_key[127:64]  <= i_cfg_data;
                REG_KEY_16_23:  r_key[191:128] <= i_cfg_data;
                REG_KEY_24_31:  r_key[255:192] <= i_cfg_data;
                REG_NONCE_0_7:  r_nonce[63:0]  <= i_cfg_data;
                REG_NONCE_8_11: r_nonce[95:64] <= i_cfg_data[31:0];
                REG_START_CNT:  r_start        <= i_cfg_data[31:0];
                REG_DERIVE:     r_derive       <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int b = 0; b < 12; b++) begin
            nonce_eff[8*b +: 8] = r_derive ? (r_key[8*b +: 8] ^ nonce_pad(b))
                                           : r_nonce[8*b +: 8];
        end
        init[0] = SIGMA_0;
        init[1] = SIGMA_1;
        init[2] = SIGMA_2;
        init[3] = SIGMA_3;
        for (int w = 0; w < 8; w++) begin
            init[4 + w] = r_key[32*w +: 32];
        end
        init[12] = r_counter;
        for (int w = 0; w < 3; w++) begin
            init[13 + w] = nonce_eff[32*w +: 32];
        end
    end

    // one add-xor-rotate step of four quarter rounds in parallel
    always_comb begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] sum, mix;
        int          dg;
        dg = int'(i_cmd.diag);
        for (int i = 0; i < 16; i++) begin
            n_x[i] = r_x[i];
        end
        for (int j = 0; j < 4; j++) begin
            ia = 4'(j);
            ib = 4'(4 + ((j + dg) & 3));
            ic = 4'(8 + ((j + 2 * dg) & 3));
            id = 4'(12 + ((j + 3 * dg) & 3));
            if (i_cmd.step[0]) begin
                sum = r_x[ic] + r_x[id];
                mix = r_x[ib] ^ sum;
            end else begin
                sum = r_x[ia] + r_x[ib];
                mix = r_x[id] ^ sum;
            end
            case (i_cmd.step)
                2'd0: begin
                    n_x[ia] = sum;
                    n_x[id] = {mix[15:0], mix[31:16]};
                end
                2'd1: begin
                    n_x[ic] = sum;
                    n_x[ib] = {mix[19:0], mix[31:20]};
                end
                2'd2: begin
                    n_x[ia] = sum;
                    n_x[id] = {mix[23:0], mix[31:24]};
                end
                2'd3: begin
                    n_x[ic] = sum;
                    n_x[ib] = {mix[24:0], mix[31:25]};
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            for (int i = 0; i < 16; i++) begin
                r_x[i] <= init[i];
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 16; i++) begin
                r_x[i] <= n_x[i];
            end
        end else if (i_cmd.fin) begin
            for (int i = 0; i < 16; i++) begin
                r_x[i] <= r_x[i] + init[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_data <= i_in_word.data_in;
            r_last <= i_in_word.end_of_message;
        end
        if (i_cmd.emit) begin
            r_out.data_out <= r_data ^ ks_byte;
            r_out.last_out <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_counter   <= '0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept && !r_in_msg) begin
                r_counter <= r_start;
                r_pos     <= '0;
                r_in_msg  <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_pos <= r_pos + 6'd1;
                if (r_pos == 6'd63) begin
                    r_counter <= r_counter + 32'd1;
                end
                if (r_last) begin
                    r_in_msg <= 1'b0;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

### sv/chacha20_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_unit: byte-wide ChaCha20 keystream XOR
// Inside a block each word goes straight from accept to emit; the first word of a
// block goes through load, 80 quarter-round steps, final add and emit in order.
// One word in flight at a time; the 80-step round unit sets the block cost.
// Synchronous active-low reset clears control and config to defaults.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cc20_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cc20_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  cc20_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output cc20_pkg::t_out_word             o_out_word
);
    import cc20_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    cc20_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    cc20_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

`ifndef ASSERT_OFF
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("input ready while output register is full");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.init, cmd.round, cmd.fin, cmd.emit}))
        else $error("more than one datapath command active");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("accepted a word while the previous one is in work");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("emitted word not presented");
`endif

endmodule
